>>> rtl/core/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// shared constants, codes and beat types of the lru byte-budget cache
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int MODE_W  = 3;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int SIZE_W  = 24;
    localparam int TIME_W  = 48;
    localparam int TOTAL_W = 30;
    localparam int LIMIT_W = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1048576);

    // request mode codes on the input port
    localparam logic [MODE_W-1:0] MODE_PUT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GET    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_EXISTS = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_EXPIRE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RESIZE = 3'd5;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_GET,
        OP_EXISTS,
        OP_REMOVE,
        OP_EXPIRE,
        OP_RESIZE,
        OP_NONE
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXEC,
        S_EVICT_FULL,
        S_INSERT,
        S_FIT,
        S_STATUS
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [SIZE_W-1:0]  bytes;
        logic [TIME_W-1:0]  expiry;
        logic [TIME_W-1:0]  now;
    } req_t;

    typedef struct packed {
        logic               kind;
        logic [KEY_W-1:0]   key;
        logic               found;
        logic [VAL_W-1:0]   value;
        logic [TIME_W-1:0]  expiry;
        logic [TOTAL_W-1:0] used;
        logic [CNT_W-1:0]   count;
        logic               last;
    } res_t;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_NOTICE = 1'b1;

endpackage

`default_nettype wire

>>> rtl/core/lbc_front.sv
// ----------------------------------------------------------------------------
// lbc_front
// request intake: decodes the mode and holds up to two requests
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_front (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          push,
    output logic                         full,
    input  wire  [lbc_pkg::MODE_W-1:0]   mode,
    input  wire  [lbc_pkg::KEY_W-1:0]    key_tag,
    input  wire  [lbc_pkg::VAL_W-1:0]    value_handle,
    input  wire  [lbc_pkg::SIZE_W-1:0]   item_bytes,
    input  wire  [lbc_pkg::TIME_W-1:0]   expiry_time,
    input  wire  [lbc_pkg::TIME_W-1:0]   current_time,
    output logic                         q_valid,
    output lbc_pkg::req_t                q_req,
    input  wire                          q_take
);

    lbc_pkg::req_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;
    lbc_pkg::req_t req_in;
    logic          do_wr, do_rd;

    always_comb
    begin
        case (mode)
            lbc_pkg::MODE_PUT:    req_in.op = lbc_pkg::OP_PUT;
            lbc_pkg::MODE_GET:    req_in.op = lbc_pkg::OP_GET;
            lbc_pkg::MODE_EXISTS: req_in.op = lbc_pkg::OP_EXISTS;
            lbc_pkg::MODE_REMOVE: req_in.op = lbc_pkg::OP_REMOVE;
            lbc_pkg::MODE_EXPIRE: req_in.op = lbc_pkg::OP_EXPIRE;
            lbc_pkg::MODE_RESIZE: req_in.op = lbc_pkg::OP_RESIZE;
            default:              req_in.op = lbc_pkg::OP_NONE;
        endcase
        req_in.key    = key_tag;
        req_in.value  = value_handle;
        req_in.bytes  = item_bytes;
        req_in.expiry = expiry_time;
        req_in.now    = current_time;
    end

    assign full    = (fill_reg == 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_req   = slot_reg[rd_ptr_reg];
    assign do_wr   = push && !full;
    assign do_rd   = q_take && q_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= req_in;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lbc_out_q.sv
// ----------------------------------------------------------------------------
// lbc_out_q
// two-deep result queue between the engine and the result port
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_out_q (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            wr,
    input  lbc_pkg::res_t  wr_data,
    output logic           wr_full,
    input  wire            pop,
    output logic           empty,
    output lbc_pkg::res_t  head
);

    lbc_pkg::res_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;
    logic          do_wr, do_rd;

    assign wr_full = (fill_reg == 2'd2);
    assign empty   = (fill_reg == 2'd0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_wr   = wr && !wr_full;
    assign do_rd   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lbc_engine.sv
// ----------------------------------------------------------------------------
// lbc_engine
// entry table, lru ranks, byte budget and the request sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_engine (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire  [lbc_pkg::LIMIT_W-1:0]  cfg_wdata,
    input  wire                          q_valid,
    input  lbc_pkg::req_t                q_req,
    output logic                         q_take,
    output logic                         res_wr,
    output lbc_pkg::res_t                res_data,
    input  wire                          res_full
);

    localparam int N  = lbc_pkg::ENTRIES;
    localparam int IW = lbc_pkg::IDX_W;
    localparam int CW = lbc_pkg::CNT_W;
    localparam int TW = lbc_pkg::TOTAL_W;

    lbc_pkg::state_t state_reg, state_next;
    lbc_pkg::req_t   req_reg;

    logic [lbc_pkg::LIMIT_W-1:0] limit_reg;
    logic [N-1:0]                valid_reg;
    logic [lbc_pkg::KEY_W-1:0]   key_reg    [N];
    logic [lbc_pkg::VAL_W-1:0]   value_reg  [N];
    logic [lbc_pkg::TIME_W-1:0]  expiry_reg [N];
    logic [lbc_pkg::SIZE_W-1:0]  size_reg   [N];
    logic [IW-1:0]               rank_reg   [N];
    logic [TW-1:0]               total_reg, total_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               notice_reg;

    logic                        hit_reg;
    logic [IW-1:0]               hit_idx_reg;
    logic                        found_reg, found_next;
    logic [lbc_pkg::VAL_W-1:0]   vo_reg, vo_next;
    logic [lbc_pkg::TIME_W-1:0]  eo_reg, eo_next;

    logic [N-1:0]  match_vec, lru_vec;
    logic [IW-1:0] match_idx, lru_idx, free_idx;
    logic [IW-1:0] lru_rank;
    logic          expired;
    logic          over_budget;
    logic          notice_room;

    // control from the output decode
    logic          act_drop, act_touch, act_insert;
    logic          act_put, act_expire, act_resize;
    logic          act_notice;
    logic [IW-1:0] drop_idx;

    // ---------------- lookups ----------------
    assign lru_rank = IW'(count_reg - CW'(1));

    always_comb
    begin
        match_idx = '0;
        lru_idx   = '0;
        free_idx  = '0;
        for (int i = 0; i < N; i++)
        begin
            match_vec[i] = valid_reg[i] && (key_reg[i] == req_reg.key);
            lru_vec[i]   = valid_reg[i] && (rank_reg[i] == lru_rank);
            if (match_vec[i])
            begin
                match_idx = match_idx | IW'(i);
            end
            if (lru_vec[i])
            begin
                lru_idx = lru_idx | IW'(i);
            end
        end
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    assign expired     = (expiry_reg[hit_idx_reg] != '0) &&
                         (expiry_reg[hit_idx_reg] <= req_reg.now);
    assign over_budget = ({{(lbc_pkg::LIMIT_W - TW){1'b0}}, total_reg} > limit_reg) &&
                         (count_reg != '0);
    assign notice_room = (notice_reg < CW'(N));

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lbc_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = lbc_pkg::S_LOOKUP;
                end
            end
            lbc_pkg::S_LOOKUP:
            begin
                state_next = lbc_pkg::S_EXEC;
            end
            lbc_pkg::S_EXEC:
            begin
                case (req_reg.op)
                    lbc_pkg::OP_PUT:
                    begin
                        if (hit_reg)
                        begin
                            state_next = lbc_pkg::S_FIT;
                        end
                        else if (count_reg == CW'(N))
                        begin
                            state_next = lbc_pkg::S_EVICT_FULL;
                        end
                        else
                        begin
                            state_next = lbc_pkg::S_INSERT;
                        end
                    end
                    lbc_pkg::OP_RESIZE:
                    begin
                        state_next = hit_reg ? lbc_pkg::S_FIT : lbc_pkg::S_STATUS;
                    end
                    default:
                    begin
                        state_next = lbc_pkg::S_STATUS;
                    end
                endcase
            end
            lbc_pkg::S_EVICT_FULL:
            begin
                if (!res_full)
                begin
                    state_next = lbc_pkg::S_INSERT;
                end
            end
            lbc_pkg::S_INSERT:
            begin
                state_next = lbc_pkg::S_FIT;
            end
            lbc_pkg::S_FIT:
            begin
                if (!over_budget)
                begin
                    state_next = lbc_pkg::S_STATUS;
                end
            end
            lbc_pkg::S_STATUS:
            begin
                if (!res_full)
                begin
                    state_next = lbc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lbc_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- outputs and actions ----------------
    always_comb
    begin
        q_take     = 1'b0;
        act_drop   = 1'b0;
        act_touch  = 1'b0;
        act_insert = 1'b0;
        act_put    = 1'b0;
        act_expire = 1'b0;
        act_resize = 1'b0;
        act_notice = 1'b0;
        drop_idx   = lru_idx;
        found_next = found_reg;
        vo_next    = vo_reg;
        eo_next    = eo_reg;
        case (state_reg)
            lbc_pkg::S_IDLE:
            begin
                q_take = q_valid;
            end
            lbc_pkg::S_EXEC:
            begin
                found_next = 1'b0;
                vo_next    = '0;
                eo_next    = '0;
                drop_idx   = hit_idx_reg;
                case (req_reg.op)
                    lbc_pkg::OP_PUT:
                    begin
                        found_next = hit_reg;
                        act_put    = hit_reg;
                        act_touch  = hit_reg;
                    end
                    lbc_pkg::OP_GET,
                    lbc_pkg::OP_EXISTS:
                    begin
                        if (hit_reg && expired)
                        begin
                            act_drop = 1'b1;
                        end
                        else if (hit_reg)
                        begin
                            found_next = 1'b1;
                            if (req_reg.op == lbc_pkg::OP_GET)
                            begin
                                vo_next   = value_reg[hit_idx_reg];
                                eo_next   = expiry_reg[hit_idx_reg];
                                act_touch = 1'b1;
                            end
                        end
                    end
                    lbc_pkg::OP_REMOVE:
                    begin
                        found_next = hit_reg;
                        act_drop   = hit_reg;
                    end
                    lbc_pkg::OP_EXPIRE:
                    begin
                        found_next = hit_reg;
                        act_expire = hit_reg;
                    end
                    lbc_pkg::OP_RESIZE:
                    begin
                        found_next = hit_reg;
                        act_resize = hit_reg;
                    end
                    default:
                    begin
                        found_next = 1'b0;
                    end
                endcase
            end
            lbc_pkg::S_EVICT_FULL:
            begin
                act_drop   = !res_full;
                act_notice = !res_full;
            end
            lbc_pkg::S_INSERT:
            begin
                act_insert = 1'b1;
            end
            lbc_pkg::S_FIT:
            begin
                if (over_budget)
                begin
                    // past the notice cap an eviction goes silently
                    act_notice = notice_room && !res_full;
                    act_drop   = !notice_room || !res_full;
                end
            end
            default:
            begin
                q_take = 1'b0;
            end
        endcase
    end

    // result beat
    always_comb
    begin
        res_wr = 1'b0;
        if (act_notice)
        begin
            res_wr         = 1'b1;
            res_data.kind  = lbc_pkg::KIND_NOTICE;
            res_data.key   = key_reg[lru_idx];
            res_data.found = 1'b0;
            res_data.value = '0;
            res_data.expiry = '0;
            res_data.last  = 1'b0;
        end
        else
        begin
            res_wr          = (state_reg == lbc_pkg::S_STATUS) && !res_full;
            res_data.kind   = lbc_pkg::KIND_STATUS;
            res_data.key    = req_reg.key;
            res_data.found  = found_reg;
            res_data.value  = vo_reg;
            res_data.expiry = eo_reg;
            res_data.last   = 1'b1;
        end
        res_data.used  = total_next;
        res_data.count = count_next;
    end

    // running totals
    always_comb
    begin
        total_next = total_reg;
        count_next = count_reg;
        if (act_drop)
        begin
            total_next = total_reg - TW'(size_reg[drop_idx]);
            count_next = count_reg - CW'(1);
        end
        else if (act_put || act_resize)
        begin
            total_next = total_reg - TW'(size_reg[hit_idx_reg]) + TW'(req_reg.bytes);
        end
        else if (act_insert)
        begin
            total_next = total_reg + TW'(req_reg.bytes);
            count_next = count_reg + CW'(1);
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lbc_pkg::S_IDLE;
            limit_reg  <= lbc_pkg::LIMIT_RESET;
            valid_reg  <= '0;
            total_reg  <= '0;
            count_reg  <= '0;
            notice_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (act_drop)
            begin
                valid_reg[drop_idx] <= 1'b0;
            end
            if (act_insert)
            begin
                valid_reg[free_idx] <= 1'b1;
            end
            if (state_reg == lbc_pkg::S_LOOKUP)
            begin
                notice_reg <= '0;
            end
            else if (act_notice)
            begin
                notice_reg <= notice_reg + CW'(1);
            end
        end
    end

    // ---------------- table payload ----------------
    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            req_reg <= q_req;
        end
        if (state_reg == lbc_pkg::S_LOOKUP)
        begin
            hit_reg     <= |match_vec;
            hit_idx_reg <= match_idx;
        end
        found_reg <= found_next;
        vo_reg    <= vo_next;
        eo_reg    <= eo_next;

        if (act_put)
        begin
            value_reg[hit_idx_reg]  <= req_reg.value;
            expiry_reg[hit_idx_reg] <= req_reg.expiry;
            size_reg[hit_idx_reg]   <= req_reg.bytes;
        end
        if (act_expire)
        begin
            expiry_reg[hit_idx_reg] <= req_reg.expiry;
        end
        if (act_resize)
        begin
            size_reg[hit_idx_reg] <= req_reg.bytes;
        end
        if (act_insert)
        begin
            key_reg[free_idx]    <= req_reg.key;
            value_reg[free_idx]  <= req_reg.value;
            expiry_reg[free_idx] <= req_reg.expiry;
            size_reg[free_idx]   <= req_reg.bytes;
        end

        // lru ranks: 0 is most recent
        for (int j = 0; j < N; j++)
        begin
            if (act_drop && valid_reg[j] && (rank_reg[j] > rank_reg[drop_idx]))
            begin
                rank_reg[j] <= rank_reg[j] - IW'(1);
            end
            else if (act_touch && valid_reg[j] && (rank_reg[j] < rank_reg[hit_idx_reg]))
            begin
                rank_reg[j] <= rank_reg[j] + IW'(1);
            end
            else if (act_insert && valid_reg[j])
            begin
                rank_reg[j] <= rank_reg[j] + IW'(1);
            end
        end
        if (act_touch)
        begin
            rank_reg[hit_idx_reg] <= '0;
        end
        if (act_insert)
        begin
            rank_reg[free_idx] <= '0;
        end
    end

    // ---------------- checks ----------------
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == count_reg)
        else $error("entry count out of step with valid bits");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(N))
        else $error("entry count beyond table size");

    a_notice_cap: assert property (@(posedge clk) disable iff (!rst_n)
        notice_reg <= CW'(N))
        else $error("notice count beyond cap");

    a_insert_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        act_insert |-> (count_reg < CW'(N)))
        else $error("insert into a full table");

endmodule

`default_nettype wire

>>> rtl/core/lru_byte_budget_cache.sv
// ----------------------------------------------------------------------------
// lru_byte_budget_cache
// key-value cache table with lru order, byte budget and lazy expiry
// ----------------------------------------------------------------------------
//  channel   handshake         beat
//  request   push / full       mode, key_tag, value_handle, item_bytes,
//                              expiry_time, current_time
//  result    empty / pop       kind, key_out, found, value_out, expiry_out,
//                              used_bytes, entry_count, last
//  config    cfg_we            cfg_wdata (byte limit)
//
//  a request passes take, key match, execute and status; a put or resize
//  hit adds a budget check, a new-key put adds insert and check (plus one
//  lru eviction when full), and each budget eviction repeats the check
//  reset clears the valid bits, byte total, entry count and sets the limit
//  a full result queue stalls the engine; a two-deep request queue keeps
//  intake going meanwhile
// ----------------------------------------------------------------------------
`default_nettype none

module lru_byte_budget_cache (
    input  wire                          clk,
    input  wire                          rst_n,
    // request side
    input  wire                          push,
    output logic                         full,
    input  wire  [lbc_pkg::MODE_W-1:0]   mode,
    input  wire  [lbc_pkg::KEY_W-1:0]    key_tag,
    input  wire  [lbc_pkg::VAL_W-1:0]    value_handle,
    input  wire  [lbc_pkg::SIZE_W-1:0]   item_bytes,
    input  wire  [lbc_pkg::TIME_W-1:0]   expiry_time,
    input  wire  [lbc_pkg::TIME_W-1:0]   current_time,
    // byte limit register
    input  wire                          cfg_we,
    input  wire  [lbc_pkg::LIMIT_W-1:0]  cfg_wdata,
    // result side
    output logic                         empty,
    input  wire                          pop,
    output logic                         kind,
    output logic [lbc_pkg::KEY_W-1:0]    key_out,
    output logic                         found,
    output logic [lbc_pkg::VAL_W-1:0]    value_out,
    output logic [lbc_pkg::TIME_W-1:0]   expiry_out,
    output logic [lbc_pkg::TOTAL_W-1:0]  used_bytes,
    output logic [lbc_pkg::CNT_W-1:0]    entry_count,
    output logic                         last
);

    // front to back
    logic          q_valid;
    logic          q_take;
    lbc_pkg::req_t q_req;

    // back to result queue
    logic          res_wr;
    logic          res_full;
    lbc_pkg::res_t res_data;
    lbc_pkg::res_t head;

    // intake and mode decode
    lbc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .key_tag      (key_tag),
        .value_handle (value_handle),
        .item_bytes   (item_bytes),
        .expiry_time  (expiry_time),
        .current_time (current_time),
        .q_valid      (q_valid),
        .q_req        (q_req),
        .q_take       (q_take)
    );

    // table, lru ranks and sequencer
    lbc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_req     (q_req),
        .q_take    (q_take),
        .res_wr    (res_wr),
        .res_data  (res_data),
        .res_full  (res_full)
    );

    // result beats wait here for pop
    lbc_out_q u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_wr),
        .wr_data (res_data),
        .wr_full (res_full),
        .pop     (pop),
        .empty   (empty),
        .head    (head)
    );

    assign kind        = head.kind;
    assign key_out     = head.key;
    assign found       = head.found;
    assign value_out   = head.value;
    assign expiry_out  = head.expiry;
    assign used_bytes  = head.used;
    assign entry_count = head.count;
    assign last        = head.last;

endmodule

`default_nettype wire
